@@ hw/rtl/serial_memory_access_protocol_macros.svh @@
// Assertion macros for the serial memory access protocol block.
// Each check is sampled on the rising edge of clk and is disabled during reset.
`ifndef SERIAL_MEMORY_ACCESS_PROTOCOL_MACROS_SVH
`define SERIAL_MEMORY_ACCESS_PROTOCOL_MACROS_SVH
`ifndef SYNTHESIS
`define SMAP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smap: same-cycle check failed");
`define SMAP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smap: next-cycle check failed");
`else
`define SMAP_ASSERT_IMP(lbl, ante, cons)
`define SMAP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/smap_pkg.sv @@
// ----------------------------------------------------------------------------
// smap_pkg
// Shared constants, types and text tables of the serial memory access block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smap_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_OK  = 8'h24;
    localparam logic [7:0] CH_ERR = 8'h21;

    localparam logic [7:0] CMD_IDENT = 8'h3F;
    localparam logic [7:0] CMD_WRITE = 8'h77;
    localparam logic [7:0] CMD_READ  = 8'h72;
    localparam logic [7:0] CMD_REG   = 8'h67;
    localparam logic [7:0] CMD_START = 8'h73;

    localparam logic [7:0] ERR_PARAM   = 8'h70;
    localparam logic [7:0] ERR_UNKNOWN = 8'h75;
    localparam logic [7:0] ERR_FORMAT  = 8'h66;
    localparam logic [7:0] ERR_SIZE    = 8'h73;

    localparam logic [31:0] CPU_WORD0_RESET = 32'hCAFEBABE;
    localparam logic [31:0] CPU_WORD1_RESET = 32'hDEADBEEF;
    localparam logic [31:0] PSR_RESET       = 32'd467;
    localparam logic [31:0] POINTER_RESET   = 32'd0;
    localparam logic [31:0] PSR_HYP         = 32'h0000_01DA;

    localparam logic [7:0] NUM_REGS    = 8'd5;
    localparam logic [7:0] NUM_CPU     = 8'd4;
    localparam logic [4:0] IDENT_LEN   = 5'd14;
    localparam logic [4:0] SYNC_LEN    = 5'd4;
    localparam logic [4:0] ERR_LEN     = 5'd5;
    localparam logic [4:0] REG_LEN     = 5'd4;

    localparam logic [1:0] CFG_PSR     = 2'd0;
    localparam logic [1:0] CFG_POINTER = 2'd1;

    // Control of the payload buffer ports.
    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_be;
        logic       rd_en;
    } pbuf_ctl_t;

    // Control of the target memory port.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tmem_ctl_t;

    function automatic logic [7:0] ident_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0:    c = 8'h6D;
            4'd1:    c = 8'h69;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h69;
            4'd4:    c = 8'h70;
            4'd5:    c = 8'h69;
            4'd6:    c = 8'h20;
            4'd7:    c = 8'h62;
            4'd8:    c = 8'h6F;
            4'd9:    c = 8'h6F;
            4'd10:   c = 8'h74;
            4'd11:   c = 8'h6C;
            4'd12:   c = 8'h64;
            4'd13:   c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sync_char(input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = 8'h53;
            2'd1:    c = 8'h59;
            2'd2:    c = 8'h4E;
            default: c = 8'h43;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/serial_memory_access_protocol.sv @@
// A request that ends a packet reaches the reply header through the dispatch state and the
// header state (a sync line end or a too-long length skips dispatch); a well-formed write
// or nonzero read first runs its word loop, and each data byte of the reply passes the
// fetch state, where the payload buffer row is read, before it enters the output register.
// Received bytes stall while the sequencer is busy; the next request waits until the
// reply's last byte has entered the output register.
// Reset (rst_n, asynchronous) clears control state and the buffer's valid bits.
// ----------------------------------------------------------------------------
// serial_memory_access_protocol
// Frames received bytes into packets, runs the commands against the payload
// buffer, the target memory and the register file, and sends framed replies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_memory_access_protocol
    import smap_pkg::*;
#(
    parameter int BUFFER_BYTES = 32,
    parameter int MEM_WORDS    = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Received bytes.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // Reply bytes.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    output logic        start_request,
    output logic [2:0]  start_options,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    `include "serial_memory_access_protocol_macros.svh"

    // Byte counters must hold the buffer size itself.
    localparam int IDX_W      = $clog2(BUFFER_BYTES) + 1;
    localparam int ROWS       = (BUFFER_BYTES + 3) / 4;
    localparam int ROW_W      = $clog2(ROWS);
    // Word index = pointer from bit 2; MEM_WORDS must be a power of two, unchecked.
    localparam int MEM_ADDR_W = $clog2(MEM_WORDS);

    // Sequencer states.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DISP  = 11'b000_0000_0010,
        S_WRD   = 11'b000_0000_0100,
        S_WWR   = 11'b000_0000_1000,
        S_RRD   = 11'b000_0001_0000,
        S_RWR   = 11'b000_0010_0000,
        S_HDR   = 11'b000_0100_0000,
        S_CNT   = 11'b000_1000_0000,
        S_FETCH = 11'b001_0000_0000,
        S_DATA  = 11'b010_0000_0000,
        S_SUM   = 11'b100_0000_0000
    } state_t;

    // Packet framing phases.
    typedef enum logic [3:0] {
        PH_CMD  = 4'b0001,
        PH_SYNC = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // Where the data bytes of a reply come from.
    typedef enum logic [2:0] {
        SRC_IDENT,
        SRC_SYNC,
        SRC_ERR,
        SRC_REG,
        SRC_BUF
    } src_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [IDX_W-1:0]   len_reg, len_next;
    logic [7:0]         lbyte_reg, lbyte_next;
    logic [IDX_W-1:0]   rcvd_reg, rcvd_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         rsum_reg, rsum_next;
    logic [7:0]         pcount_reg, pcount_next;
    logic [7:0]         p0_reg, p0_next;
    logic [31:0]        gval_reg, gval_next;
    logic [31:0]        cpu_reg [4];
    logic [31:0]        cpu_next [4];
    logic [31:0]        ptr_reg, ptr_next;
    logic               ok_reg, ok_next;
    src_t               src_reg, src_next;
    logic [IDX_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [7:0]         osum_reg, osum_next;
    logic [7:0]         err_reg, err_next;
    logic               sreq_reg, sreq_next;
    logic [2:0]         sopt_reg, sopt_next;
    logic [ROW_W:0]     row_reg, row_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         tx_reg, tx_next;
    logic               last_reg, last_next;
    logic               oreq_reg, oreq_next;
    logic [2:0]         oopt_reg, oopt_next;

    pbuf_ctl_t          pb_ctl;
    logic [ROW_W-1:0]   pb_wr_row;
    logic [ROW_W-1:0]   pb_rd_row;
    logic [31:0]        pb_wr_data;
    logic [31:0]        pb_rd_data;
    tmem_ctl_t          tm_ctl;
    logic [31:0]        tm_rd_data;
    logic [MEM_ADDR_W-1:0] tm_addr;

    logic               in_accept;
    logic               out_free;
    logic               is_eol;
    logic [7:0]         sum_add;
    logic [IDX_W-1:0]   rcvd_inc;
    logic [31:0]        reg_sel;
    logic [7:0]         data_byte;
    logic [ROW_W+2:0]   next_off;
    logic [IDX_W:0]     dlen;
    logic [ROW_W+1:0]   lane_idx;

    // Requests are taken only when the sequencer has nothing left to do.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // The output register frees as its byte is taken.
    assign out_free = !out_valid_reg || !out_stall;

    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign sum_add  = sum_reg + rx_byte;
    assign rcvd_inc = rcvd_reg + 1'b1;
    assign tm_addr  = ptr_reg[MEM_ADDR_W+1:2];
    assign next_off = {row_reg + 1'b1, 2'b00};
    assign dlen     = {1'b0, len_reg} - 1'b1;

    assign reg_sel  = (p0_reg < NUM_CPU) ? cpu_reg[p0_reg[1:0]] : ptr_reg;

    always_comb
    begin
        case (src_reg)
            SRC_IDENT: data_byte = ident_char(k_reg[3:0]);
            SRC_SYNC:  data_byte = sync_char(k_reg[1:0]);
            SRC_REG:   data_byte = reg_sel[8*k_reg[1:0] +: 8];
            SRC_BUF:   data_byte = pb_rd_data[8*k_reg[1:0] +: 8];
            SRC_ERR:
            begin
                case (k_reg[2:0])
                    3'd0:    data_byte = err_reg;
                    3'd1:    data_byte = cmd_reg;
                    3'd2:    data_byte = lbyte_reg;
                    3'd3:    data_byte = rsum_reg;
                    default: data_byte = pcount_reg;
                endcase
            end
            default:   data_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        lbyte_next  = lbyte_reg;
        rcvd_next   = rcvd_reg;
        sum_next    = sum_reg;
        rsum_next   = rsum_reg;
        pcount_next = pcount_reg;
        p0_next     = p0_reg;
        gval_next   = gval_reg;
        for (int i = 0; i < 4; i++)
        begin
            cpu_next[i] = cpu_reg[i];
        end
        ptr_next    = ptr_reg;
        ok_next     = ok_reg;
        src_next    = src_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        osum_next   = osum_reg;
        err_next    = err_reg;
        sreq_next   = sreq_reg;
        sopt_next   = sopt_reg;
        row_next    = row_reg;
        tx_next     = tx_reg;
        last_next   = last_reg;
        oreq_next   = oreq_reg;
        oopt_next   = oopt_reg;
        out_valid_next = out_valid_reg && out_stall;
        pb_ctl      = '0;
        pb_wr_row   = rcvd_reg[ROW_W+1:2];
        pb_rd_row   = k_reg[ROW_W+1:2];
        pb_wr_data  = {4{rx_byte}};
        tm_ctl      = '0;
        lane_idx    = '0;

        // Configuration writes also reload the registers that they seed.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PSR:
                begin
                    cpu_next[2] = cfg_data;
                end
                CFG_POINTER:
                begin
                    cpu_next[3] = cfg_data;
                    ptr_next    = cfg_data;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (phase_reg)
                        PH_SYNC:
                        begin
                            // Bytes are dropped until a line end, which answers SYNC.
                            if (is_eol)
                            begin
                                phase_next = PH_CMD;
                                ok_next    = 1'b1;
                                src_next   = SRC_SYNC;
                                n_next     = IDX_W'(SYNC_LEN);
                                state_next = S_HDR;
                            end
                        end
                        PH_LEN:
                        begin
                            if (rx_byte >= 8'(BUFFER_BYTES))
                            begin
                                // Too long: answered at once, previous sum kept.
                                lbyte_next = 8'h00;
                                phase_next = PH_CMD;
                                ok_next    = 1'b0;
                                src_next   = SRC_ERR;
                                err_next   = ERR_FORMAT;
                                n_next     = IDX_W'(ERR_LEN);
                                state_next = S_HDR;
                            end
                            else
                            begin
                                len_next  = rx_byte[IDX_W-1:0];
                                sum_next  = cmd_reg + rx_byte;
                                rcvd_next = '0;
                                gval_next = '0;
                                if (rx_byte == 8'h00)
                                begin
                                    // Empty packet: its payload length reads as minus one.
                                    rsum_next  = cmd_reg;
                                    lbyte_next = 8'hFF;
                                    phase_next = PH_CMD;
                                    state_next = S_DISP;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            pb_ctl.wr_en = 1'b1;
                            pb_ctl.wr_be = 4'b0001 << rcvd_reg[1:0];
                            sum_next     = sum_add;
                            rcvd_next    = rcvd_inc;
                            if (rcvd_reg == '0)
                            begin
                                p0_next = rx_byte;
                            end
                            if ((rcvd_reg != '0) && (rcvd_inc < len_reg))
                            begin
                                gval_next = {gval_reg[23:0], rx_byte};
                            end
                            if (rcvd_inc >= len_reg)
                            begin
                                rsum_next  = sum_add;
                                lbyte_next = 8'(len_reg) - 8'd1;
                                phase_next = PH_CMD;
                                state_next = S_DISP;
                            end
                        end
                        default:
                        begin
                            if (rx_byte == CH_DOT)
                            begin
                                phase_next = PH_SYNC;
                            end
                            else if (!is_eol)
                            begin
                                cmd_next    = rx_byte;
                                pcount_next = pcount_reg + 8'd1;
                                phase_next  = PH_LEN;
                            end
                        end
                    endcase
                end
            end

            S_DISP:
            begin
                state_next = S_HDR;
                ok_next    = 1'b1;
                src_next   = SRC_BUF;
                n_next     = '0;
                row_next   = '0;
                if (rsum_reg != 8'h00)
                begin
                    ok_next  = 1'b0;
                    src_next = SRC_ERR;
                    err_next = ERR_FORMAT;
                    n_next   = IDX_W'(ERR_LEN);
                end
                else
                begin
                    case (cmd_reg)
                        CMD_IDENT:
                        begin
                            if (len_reg == IDX_W'(1))
                            begin
                                src_next = SRC_IDENT;
                                n_next   = IDX_W'(IDENT_LEN);
                            end
                            else
                            begin
                                ok_next  = 1'b0;
                                src_next = SRC_ERR;
                                err_next = ERR_SIZE;
                                n_next   = IDX_W'(ERR_LEN);
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (len_reg >= IDX_W'(2))
                            begin
                                state_next = S_WRD;
                            end
                            else
                            begin
                                ok_next  = 1'b0;
                                src_next = SRC_ERR;
                                err_next = ERR_SIZE;
                                n_next   = IDX_W'(ERR_LEN);
                            end
                        end
                        CMD_READ:
                        begin
                            if (len_reg >= IDX_W'(2))
                            begin
                                // The byte count is capped at the buffer size.
                                if (p0_reg > 8'(BUFFER_BYTES))
                                begin
                                    n_next = IDX_W'(BUFFER_BYTES);
                                end
                                else
                                begin
                                    n_next = IDX_W'(p0_reg);
                                end
                                if (p0_reg != 8'h00)
                                begin
                                    state_next = S_RRD;
                                end
                            end
                            else
                            begin
                                ok_next  = 1'b0;
                                src_next = SRC_ERR;
                                err_next = ERR_SIZE;
                                n_next   = IDX_W'(ERR_LEN);
                            end
                        end
                        CMD_REG:
                        begin
                            if ((len_reg < IDX_W'(2)) || (len_reg > IDX_W'(6)))
                            begin
                                ok_next  = 1'b0;
                                src_next = SRC_ERR;
                                err_next = ERR_SIZE;
                                n_next   = IDX_W'(ERR_LEN);
                            end
                            else if (p0_reg >= NUM_REGS)
                            begin
                                ok_next  = 1'b0;
                                src_next = SRC_ERR;
                                err_next = ERR_PARAM;
                                n_next   = IDX_W'(ERR_LEN);
                            end
                            else
                            begin
                                if (len_reg > IDX_W'(2))
                                begin
                                    if (p0_reg < NUM_CPU)
                                    begin
                                        cpu_next[p0_reg[1:0]] = gval_reg;
                                    end
                                    else
                                    begin
                                        ptr_next = gval_reg;
                                    end
                                end
                                src_next = SRC_REG;
                                n_next   = IDX_W'(REG_LEN);
                            end
                        end
                        CMD_START:
                        begin
                            if (len_reg == IDX_W'(2))
                            begin
                                // Hyp mode forces the saved status word.
                                sreq_next = 1'b1;
                                sopt_next = p0_reg[2:0];
                                if (p0_reg[2])
                                begin
                                    cpu_next[2] = PSR_HYP;
                                end
                            end
                            else
                            begin
                                ok_next  = 1'b0;
                                src_next = SRC_ERR;
                                err_next = ERR_SIZE;
                                n_next   = IDX_W'(ERR_LEN);
                            end
                        end
                        default:
                        begin
                            ok_next  = 1'b0;
                            src_next = SRC_ERR;
                            err_next = ERR_UNKNOWN;
                            n_next   = IDX_W'(ERR_LEN);
                        end
                    endcase
                end
            end

            // Write loop: one buffer row is read, then stored to the target word.
            S_WRD:
            begin
                pb_ctl.rd_en = 1'b1;
                pb_rd_row    = row_reg[ROW_W-1:0];
                state_next   = S_WWR;
            end
            S_WWR:
            begin
                tm_ctl.wr_en = 1'b1;
                ptr_next     = ptr_reg + 32'd4;
                if ((ROW_W+3)'(next_off) < dlen)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = S_HDR;
                end
            end

            // Read loop: one target word is read, then stored into a buffer row.
            S_RRD:
            begin
                tm_ctl.rd_en = 1'b1;
                state_next   = S_RWR;
            end
            S_RWR:
            begin
                pb_ctl.wr_en = 1'b1;
                pb_wr_row    = row_reg[ROW_W-1:0];
                pb_wr_data   = tm_rd_data;
                for (int l = 0; l < 4; l++)
                begin
                    lane_idx        = {row_reg[ROW_W-1:0], 2'(l)};
                    pb_ctl.wr_be[l] = ({1'b0, lane_idx} < (ROW_W+3)'(BUFFER_BYTES));
                end
                ptr_next = ptr_reg + 32'd4;
                if (next_off < (ROW_W+3)'(n_reg))
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_RRD;
                end
                else
                begin
                    state_next = S_HDR;
                end
            end

            S_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_next        = ok_reg ? CH_OK : CH_ERR;
                    last_next      = 1'b0;
                    oreq_next      = 1'b0;
                    oopt_next      = '0;
                    osum_next      = ok_reg ? CH_OK : CH_ERR;
                    state_next     = S_CNT;
                end
            end
            S_CNT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_next        = 8'(n_reg) + 8'd1;
                    osum_next      = osum_reg + 8'(n_reg) + 8'd1;
                    k_next         = '0;
                    state_next     = (n_reg == '0) ? S_SUM : S_FETCH;
                end
            end
            S_FETCH:
            begin
                pb_ctl.rd_en = 1'b1;
                state_next   = S_DATA;
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_next        = data_byte;
                    osum_next      = osum_reg + data_byte;
                    k_next         = k_reg + 1'b1;
                    state_next     = ((k_reg + 1'b1) == n_reg) ? S_SUM : S_FETCH;
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_next        = 8'h00 - osum_reg;
                    last_next      = 1'b1;
                    oreq_next      = sreq_reg;
                    oopt_next      = sopt_reg;
                    sreq_next      = 1'b0;
                    sopt_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CMD;
            cmd_reg       <= '0;
            len_reg       <= '0;
            lbyte_reg     <= '0;
            rcvd_reg      <= '0;
            sum_reg       <= '0;
            rsum_reg      <= '0;
            pcount_reg    <= '0;
            p0_reg        <= '0;
            gval_reg      <= '0;
            cpu_reg[0]    <= CPU_WORD0_RESET;
            cpu_reg[1]    <= CPU_WORD1_RESET;
            cpu_reg[2]    <= PSR_RESET;
            cpu_reg[3]    <= POINTER_RESET;
            ptr_reg       <= POINTER_RESET;
            ok_reg        <= 1'b0;
            src_reg       <= SRC_BUF;
            n_reg         <= '0;
            k_reg         <= '0;
            osum_reg      <= '0;
            err_reg       <= '0;
            sreq_reg      <= 1'b0;
            sopt_reg      <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            tx_reg        <= '0;
            last_reg      <= 1'b0;
            oreq_reg      <= 1'b0;
            oopt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            lbyte_reg     <= lbyte_next;
            rcvd_reg      <= rcvd_next;
            sum_reg       <= sum_next;
            rsum_reg      <= rsum_next;
            pcount_reg    <= pcount_next;
            p0_reg        <= p0_next;
            gval_reg      <= gval_next;
            for (int i = 0; i < 4; i++)
            begin
                cpu_reg[i] <= cpu_next[i];
            end
            ptr_reg       <= ptr_next;
            ok_reg        <= ok_next;
            src_reg       <= src_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            osum_reg      <= osum_next;
            err_reg       <= err_next;
            sreq_reg      <= sreq_next;
            sopt_reg      <= sopt_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            tx_reg        <= tx_next;
            last_reg      <= last_next;
            oreq_reg      <= oreq_next;
            oopt_reg      <= oopt_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_byte       = tx_reg;
    assign last_byte     = last_reg;
    assign start_request = oreq_reg;
    assign start_options = oopt_reg;

    smap_pbuf #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_pbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (pb_ctl),
        .wr_row  (pb_wr_row),
        .wr_data (pb_wr_data),
        .rd_row  (pb_rd_row),
        .rd_data (pb_rd_data)
    );

    smap_tmem #(
        .WORDS  (MEM_WORDS),
        .ADDR_W (MEM_ADDR_W)
    ) u_tmem (
        .clk     (clk),
        .ctl     (tm_ctl),
        .addr    (tm_addr),
        .wr_data (pb_rd_data),
        .rd_data (tm_rd_data)
    );

    // The checksum byte always closes the reply that the sequencer sends.
    `SMAP_ASSERT_NXT(a_sum_last, (state_reg == S_SUM) && out_free, out_valid && last_byte)
    // A reply header is either the success or the error mark.
    `SMAP_ASSERT_NXT(a_hdr_mark, (state_reg == S_HDR) && out_free, (tx_byte == CH_OK) || (tx_byte == CH_ERR))
    // An oversized length byte starts an error reply right away.
    `SMAP_ASSERT_NXT(a_too_long, in_accept && (phase_reg == PH_LEN) && (rx_byte >= 8'(BUFFER_BYTES)), (state_reg == S_HDR) && !ok_reg)

endmodule

@@ hw/rtl/smap_pbuf.sv @@
// ----------------------------------------------------------------------------
// smap_pbuf
// Payload buffer: word rows with byte enables; unwritten bytes read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smap_pbuf
    import smap_pkg::*;
#(
    parameter int ROWS  = 8,
    parameter int ROW_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pbuf_ctl_t        ctl,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [31:0]      wr_data,
    input  logic [ROW_W-1:0] rd_row,
    output logic [31:0]      rd_data
);

    logic [31:0]         mem [ROWS];
    logic [31:0]         rdata_reg;
    logic [3:0]          mask_reg;
    logic [ROWS*4-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (ctl.wr_en && ctl.wr_be[l])
            begin
                mem[wr_row][8*l +: 8] <= wr_data[8*l +: 8];
            end
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_row];
        end
    end

    // Valid bits give the buffer its all-zero reset without a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[{wr_row, 2'b00} +: 4] <= valid_reg[{wr_row, 2'b00} +: 4] | ctl.wr_be;
            end
            if (ctl.rd_en)
            begin
                mask_reg <= valid_reg[{rd_row, 2'b00} +: 4];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            rd_data[8*l +: 8] = mask_reg[l] ? rdata_reg[8*l +: 8] : 8'h00;
        end
    end

endmodule

@@ hw/rtl/smap_tmem.sv @@
// ----------------------------------------------------------------------------
// smap_tmem
// Target word memory: one port, registered synchronous read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smap_tmem
    import smap_pkg::*;
#(
    parameter int WORDS  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  tmem_ctl_t         ctl,
    input  logic [ADDR_W-1:0] addr,
    input  logic [31:0]       wr_data,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule
